[rtl/core/assert_macros.svh]
// Assertion macros shared by the queue RTL.
// No dependencies; files that check their logic include this header.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
// Property must hold at every clock edge outside reset.
`define CSPQ_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("queue assertion failed");
// Condition must never be seen at a clock edge outside reset.
`define CSPQ_ASSERT_NEVER(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) \
    else $error("queue forbidden condition seen");
`else
`define CSPQ_ASSERT(name, clk, rst_n, prop)
`define CSPQ_ASSERT_NEVER(name, clk, rst_n, prop)
`endif

`endif

[rtl/core/cspq_pkg.sv]
// Shared types, codes and helpers of the coalescing sorted priority queue.
// No dependencies; used by cspq_cell and the top level.
`default_nettype none

package cspq_pkg;

  localparam int CAPACITY_DEF = 16;

  localparam int OP_W   = 2;
  localparam int KEY_W  = 32;
  localparam int AMT_W  = 32;
  localparam int TAG_W  = 16;
  localparam int ST_W   = 2;
  localparam int FILL_W = 5;

  localparam logic [OP_W-1:0] OP_PUSH = 2'd0;
  localparam logic [OP_W-1:0] OP_POP  = 2'd1;
  localparam logic [OP_W-1:0] OP_PEEK = 2'd2;

  localparam logic [ST_W-1:0] ST_OK     = 2'd0;
  localparam logic [ST_W-1:0] ST_MERGED = 2'd1;
  localparam logic [ST_W-1:0] ST_EMPTY  = 2'd2;
  localparam logic [ST_W-1:0] ST_FULL   = 2'd3;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [AMT_W-1:0] amount;
    logic [TAG_W-1:0] tag;
  } entry_t;

  // Broadcast command to every cell, at most one bit set.
  typedef struct packed {
    logic insert;
    logic merge;
    logic pop;
  } ctrl_t;

  function automatic logic [AMT_W-1:0] sat_add(input logic [AMT_W-1:0] a,
                                               input logic [AMT_W-1:0] b);
    logic [AMT_W:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return sum[AMT_W] ? {AMT_W{1'b1}} : sum[AMT_W-1:0];
  endfunction

endpackage

`default_nettype wire

[rtl/core/cspq_cell.sv]
// One slot of the sorted shift-register queue.
// Depends on cspq_pkg; instantiated in a chain by the top level.
`default_nettype none

module cspq_cell import cspq_pkg::*; (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire ctrl_t  ctrl_i,
  input  wire entry_t in_entry_i,
  input  wire logic   left_valid_i,
  input  wire entry_t left_entry_i,
  input  wire logic   left_lt_i,
  input  wire logic   right_valid_i,
  input  wire entry_t right_entry_i,
  output logic        valid_o,
  output entry_t      entry_o,
  output logic        lt_o,
  output logic        eq_o
);

  logic   valid_q, valid_d;
  entry_t entry_q, entry_d;

  assign lt_o = valid_q && (entry_q.key < in_entry_i.key);
  assign eq_o = valid_q && (entry_q.key == in_entry_i.key);

  always_comb begin
    valid_d = valid_q;
    entry_d = entry_q;
    if (ctrl_i.merge && eq_o) begin
      entry_d.amount = sat_add(entry_q.amount, in_entry_i.amount);
    end else if (ctrl_i.insert && !lt_o) begin
      // first slot not below the key takes the new item, the rest move tailward
      if (left_lt_i) begin
        valid_d = 1'b1;
        entry_d = in_entry_i;
      end else begin
        valid_d = left_valid_i;
        entry_d = left_entry_i;
      end
    end else if (ctrl_i.pop) begin
      valid_d = right_valid_i;
      entry_d = right_entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign valid_o = valid_q;
  assign entry_o = entry_q;

endmodule

`default_nettype wire

[rtl/core/coalescing_sorted_priority_queue.sv]
// Top level of the coalescing sorted priority queue: a chain of cspq_cell slots.
// Depends on cspq_pkg, cspq_cell and assert_macros.svh.
//
//   port group      dir  handshake        contents
//   command         in   start_i/busy_o   op_i, key_i, amount_i, tag_i
//   result          out  done_o strobe    status_o, is_empty_o, head_*_o, fill_count_o
//
// For each item all slots compare against the key in parallel and
// update at the accepting edge; the result strobes in the following cycle.
// busy_o stays low, so a new item may be started every cycle.
// Reset empties the queue at once; slot payloads are not cleared.
// The receiver cannot stall; a result is shown for its one strobe cycle only.
`default_nettype none

`include "assert_macros.svh"

module coalescing_sorted_priority_queue import cspq_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  output logic                   busy_o,
  input  wire logic [OP_W-1:0]   op_i,
  input  wire logic [KEY_W-1:0]  key_i,
  input  wire logic [AMT_W-1:0]  amount_i,
  input  wire logic [TAG_W-1:0]  tag_i,
  output logic                   done_o,
  output logic [ST_W-1:0]        status_o,
  output logic                   is_empty_o,
  output logic [KEY_W-1:0]       head_key_o,
  output logic [AMT_W-1:0]       head_amount_o,
  output logic [TAG_W-1:0]       head_tag_o,
  output logic [FILL_W-1:0]      fill_count_o
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  logic                accept;
  logic                is_push, is_pop;
  logic                match, full, empty;
  ctrl_t               ctrl;
  entry_t              in_entry;
  logic [CAPACITY-1:0] cell_valid;
  logic [CAPACITY-1:0] cell_lt;
  logic [CAPACITY-1:0] cell_eq;
  entry_t              cell_entry [CAPACITY];

  logic [CNT_W-1:0]    fill_q, fill_d;
  logic                done_q;
  logic [ST_W-1:0]     status_q, status_d;

  assign busy_o   = 1'b0;
  assign accept   = start_i && !busy_o;
  assign is_push  = (op_i == OP_PUSH);
  assign is_pop   = (op_i == OP_POP);
  assign in_entry = '{key: key_i, amount: amount_i, tag: tag_i};

  assign match = |cell_eq;
  assign full  = cell_valid[CAPACITY-1];
  assign empty = !cell_valid[0];

  assign ctrl.insert = accept && is_push && !match && !full;
  assign ctrl.merge  = accept && is_push && match;
  assign ctrl.pop    = accept && is_pop && !empty;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic   left_valid, left_lt, right_valid;
    entry_t left_entry, right_entry;

    if (i == 0) begin : g_head
      assign left_valid = 1'b0;
      assign left_entry = '0;
      assign left_lt    = 1'b1;
    end else begin : g_mid
      assign left_valid = cell_valid[i-1];
      assign left_entry = cell_entry[i-1];
      assign left_lt    = cell_lt[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign right_valid = 1'b0;
      assign right_entry = '0;
    end else begin : g_body
      assign right_valid = cell_valid[i+1];
      assign right_entry = cell_entry[i+1];
    end

    cspq_cell u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .ctrl_i        (ctrl),
      .in_entry_i    (in_entry),
      .left_valid_i  (left_valid),
      .left_entry_i  (left_entry),
      .left_lt_i     (left_lt),
      .right_valid_i (right_valid),
      .right_entry_i (right_entry),
      .valid_o       (cell_valid[i]),
      .entry_o       (cell_entry[i]),
      .lt_o          (cell_lt[i]),
      .eq_o          (cell_eq[i])
    );
  end

  always_comb begin
    fill_d = fill_q;
    if (ctrl.insert) begin
      fill_d = fill_q + CNT_W'(1);
    end else if (ctrl.pop) begin
      fill_d = fill_q - CNT_W'(1);
    end
  end

  always_comb begin
    case (op_i)
      OP_PUSH: begin
        if (match) begin
          status_d = ST_MERGED;
        end else if (full) begin
          status_d = ST_FULL;
        end else begin
          status_d = ST_OK;
        end
      end
      default: begin
        // pop, peek and the unused code all report empty the same way
        status_d = empty ? ST_EMPTY : ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      done_q <= 1'b0;
    end else begin
      fill_q <= fill_d;
      done_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q <= status_d;
    end
  end

  assign done_o        = done_q;
  assign status_o      = status_q;
  assign is_empty_o    = empty;
  assign head_key_o    = empty ? '0 : cell_entry[0].key;
  assign head_amount_o = empty ? '0 : cell_entry[0].amount;
  assign head_tag_o    = empty ? '0 : cell_entry[0].tag;
  assign fill_count_o  = FILL_W'(fill_q);

  `CSPQ_ASSERT(a_fill_tracks_head, clk_i, rst_ni, (fill_q == '0) == empty)
  `CSPQ_ASSERT(a_fill_tracks_tail, clk_i, rst_ni, (fill_q == CNT_W'(CAPACITY)) == full)
  `CSPQ_ASSERT(a_done_follows_start, clk_i, rst_ni, accept |=> done_q)
  `CSPQ_ASSERT(a_full_drop_when_full, clk_i, rst_ni, (done_q && status_q == ST_FULL) |-> full)
  `CSPQ_ASSERT_NEVER(a_two_matches, clk_i, rst_ni, !$onehot0(cell_eq))

endmodule

`default_nettype wire

[tb/tb.sv]
// Self-checking bench for coalescing_sorted_priority_queue.
// Depends on cspq_pkg; a shadow of the sorted table predicts the head and fill of
// every item, and random push/pop bursts under several sender idle rates drive it.
`timescale 1ns / 1ps

import cspq_pkg::*;

typedef struct packed {
  logic [ST_W-1:0]   status;
  logic              is_empty;
  entry_t            head;
  logic [FILL_W-1:0] fill;
} head_report_t;

class queue_shadow;
  entry_t       slots[CAPACITY_DEF];
  int           fill;
  head_report_t pending_reports[$];
  bit           failed;

  function new();
    fill = 0;
    failed = 1'b0;
  endfunction

  function int pending();
    return pending_reports.size();
  endfunction

  // Apply one accepted item to the shadow table and queue the report it yields.
  function void note_item(logic [OP_W-1:0] op, logic [KEY_W-1:0] key,
                          logic [AMT_W-1:0] amount, logic [TAG_W-1:0] tag);
    int               pos;
    logic [AMT_W-1:0] sum;
    head_report_t     rep;
    rep.status = ST_OK;
    if (op == OP_PUSH) begin
      pos = 0;
      while (pos < fill && slots[pos].key < key) pos++;
      if (pos < fill && slots[pos].key == key) begin
        // coalesce: saturate the amount, keep the stored tag
        sum = slots[pos].amount + amount;
        if (sum < amount) sum = '1;
        slots[pos].amount = sum;
        rep.status = ST_MERGED;
      end else if (fill >= CAPACITY_DEF) begin
        rep.status = ST_FULL;
      end else begin
        for (int i = fill; i > pos; i--) slots[i] = slots[i-1];
        slots[pos].key = key;
        slots[pos].amount = amount;
        slots[pos].tag = tag;
        fill++;
      end
    end else if (op == OP_POP) begin
      if (fill == 0) begin
        rep.status = ST_EMPTY;
      end else begin
        for (int i = 1; i < fill; i++) slots[i-1] = slots[i];
        fill--;
      end
    end else if (fill == 0) begin
      // peek and the spare op code only look at the head
      rep.status = ST_EMPTY;
    end
    rep.is_empty = (fill == 0);
    rep.head = (fill > 0) ? slots[0] : '0;
    rep.fill = fill[FILL_W-1:0];
    pending_reports.push_back(rep);
  endfunction

  function void compare(string field, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h actual %h", $time, field, want, got);
      failed = 1'b1;
    end
  endfunction

  function void check_result(logic [ST_W-1:0] status, logic is_empty,
                             logic [KEY_W-1:0] head_key, logic [AMT_W-1:0] head_amount,
                             logic [TAG_W-1:0] head_tag, logic [FILL_W-1:0] fill_count);
    head_report_t want;
    if (pending_reports.size() == 0) begin
      $display("%0t: result with no item outstanding, expected none actual status %h",
               $time, status);
      failed = 1'b1;
      return;
    end
    want = pending_reports.pop_front();
    compare("status", 32'(want.status), 32'(status));
    compare("is_empty", 32'(want.is_empty), 32'(is_empty));
    compare("head_key", want.head.key, head_key);
    compare("head_amount", want.head.amount, head_amount);
    compare("head_tag", 32'(want.head.tag), 32'(head_tag));
    compare("fill_count", 32'(want.fill), 32'(fill_count));
  endfunction
endclass

module tb;
  localparam logic [OP_W-1:0] OP_SPARE = 2'd3;
  localparam int KEY_POOL    = 20;
  localparam int STALL_LIMIT = 1000;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              start_i = 1'b0;
  logic [OP_W-1:0]   op_i = OP_PEEK;
  logic [KEY_W-1:0]  key_i = '0;
  logic [AMT_W-1:0]  amount_i = '0;
  logic [TAG_W-1:0]  tag_i = '0;
  logic              busy_o;
  logic              done_o;
  logic [ST_W-1:0]   status_o;
  logic              is_empty_o;
  logic [KEY_W-1:0]  head_key_o;
  logic [AMT_W-1:0]  head_amount_o;
  logic [TAG_W-1:0]  head_tag_o;
  logic [FILL_W-1:0] fill_count_o;

  queue_shadow      shadow = new();
  logic [KEY_W-1:0] key_pool[KEY_POOL];
  int               quiet_cycles = 0;

  coalescing_sorted_priority_queue uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .op_i         (op_i),
    .key_i        (key_i),
    .amount_i     (amount_i),
    .tag_i        (tag_i),
    .done_o       (done_o),
    .status_o     (status_o),
    .is_empty_o   (is_empty_o),
    .head_key_o   (head_key_o),
    .head_amount_o(head_amount_o),
    .head_tag_o   (head_tag_o),
    .fill_count_o (fill_count_o)
  );

  always #5 clk_i = ~clk_i;

  // Check results and note accepted items; end the run if nothing moves for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o)
        shadow.check_result(status_o, is_empty_o, head_key_o, head_amount_o, head_tag_o,
                            fill_count_o);
      if (start_i && !busy_o)
        shadow.note_item(op_i, key_i, amount_i, tag_i);
      if ((start_i && !busy_o) || done_o) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("[coalescing_sorted_priority_queue] ERROR");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Idle for gap cycles first, then hold the item until it is taken.
  task automatic send_item(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] key,
                           input logic [AMT_W-1:0] amount, input logic [TAG_W-1:0] tag,
                           input int gap);
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i <= 1'b1;
    op_i <= op;
    key_i <= key;
    amount_i <= amount;
    tag_i <= tag;
    do @(posedge clk_i); while (busy_o);
  endtask

  task automatic run_directed();
    send_item(OP_POP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 0);
    send_item(OP_PEEK, '0, '0, '0, 0);
    send_item(OP_SPARE, 32'h1234_5678, '0, 16'hA5A5, 0);
    send_item(OP_PUSH, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 0);
    send_item(OP_PUSH, 32'h0000_0000, 32'h0000_0000, 16'h0000, 0);
    // merge at the head keeps tag 0, then saturate it
    send_item(OP_PUSH, 32'h0000_0000, 32'hFFFF_FFFF, 16'h1234, 0);
    send_item(OP_PUSH, 32'h0000_0000, 32'h0000_0001, 16'h4321, 0);
    send_item(OP_PUSH, 32'hFFFF_FFFF, 32'h0000_0005, 16'h0F0F, 0);
    for (int i = 1; i <= 14; i++)
      send_item(OP_PUSH, 32'h0001_0000 * i, 32'h0000_8000 + i, TAG_W'(32'h0100 + i), 0);
    // table is full: a new key drops, a stored key still merges
    send_item(OP_PUSH, 32'h0000_0008, 32'h1111_1111, 16'h7777, 0);
    send_item(OP_PUSH, 32'h0001_0000, 32'hFFFF_0000, 16'h8888, 0);
    send_item(OP_SPARE, '0, '0, '0, 0);
  endtask

  // Push-heavy and pop-heavy bursts so the table swings between empty and full.
  task automatic run_random(input int n_items, input int idle_pct);
    int               sent;
    int               burst;
    int               roll;
    int               gap;
    bit               filling;
    logic [OP_W-1:0]  op;
    logic [KEY_W-1:0] key;
    logic [AMT_W-1:0] amount;
    sent = 0;
    while (sent < n_items) begin
      filling = 1'($urandom_range(0, 1));
      burst = $urandom_range(8, 40);
      for (int b = 0; b < burst && sent < n_items; b++) begin
        roll = $urandom_range(0, 99);
        if (filling)
          op = (roll < 70) ? OP_PUSH : (roll < 85) ? OP_POP : (roll < 95) ? OP_PEEK : OP_SPARE;
        else
          op = (roll < 20) ? OP_PUSH : (roll < 85) ? OP_POP : (roll < 95) ? OP_PEEK : OP_SPARE;
        roll = $urandom_range(0, 99);
        if (roll < 80) key = key_pool[$urandom_range(0, KEY_POOL-1)];
        else if (roll < 95) key = $urandom;
        else key = $urandom_range(0, 1) ? '1 : '0;
        if (op == OP_PUSH && $urandom_range(0, 99) < 2)
          key_pool[$urandom_range(0, KEY_POOL-1)] = $urandom;
        roll = $urandom_range(0, 99);
        if (roll < 70) amount = $urandom;
        else if (roll < 90) amount = $urandom_range(0, 255);
        else amount = {16'hFFFF, 16'($urandom)};
        // idle each cycle with the given odds, so idle_pct of all cycles stay empty
        gap = 0;
        while ($urandom_range(0, 99) < idle_pct) gap++;
        send_item(op, key, amount, 16'($urandom), gap);
        sent++;
      end
    end
  endtask

  initial begin
    foreach (key_pool[i]) key_pool[i] = $urandom;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    run_directed();
    run_random(475, 0);
    run_random(475, 51);
    run_random(475, 33);
    start_i <= 1'b0;
    do @(posedge clk_i); while (shadow.pending() != 0);
    repeat (4) @(posedge clk_i);
    if (shadow.failed)
      $display("[coalescing_sorted_priority_queue] ERROR");
    else
      $display("[coalescing_sorted_priority_queue] OK");
    $finish;
  end
endmodule
